// ----- hdl/reversible_gate_cnf_emitter_assert.svh -----
// assertion macros for the emitter datapath module
// both expect signals named clock and reset in the enclosing module
`ifndef REVERSIBLE_GATE_CNF_EMITTER_ASSERT_SVH
`define REVERSIBLE_GATE_CNF_EMITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RGCE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RGCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RGCE_ASSERT_IMPL(label, ante, cons, msg)
`define RGCE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/rgce_pkg.sv -----
package rgce_pkg;

   localparam int LIT_W           = 32;
   localparam int TAIL_FIRST_WIRE = 78;
   localparam int MAX_RESULTS     = 64;

   // request function codes
   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_GATE   = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UNIT_RD,
      ST_UNIT_EMIT,
      ST_GATE_RD_T,
      ST_GATE_RD_C1,
      ST_GATE_RD_C2,
      ST_GATE_EMIT,
      ST_ERR_EMIT
   } state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_UNIT,
      RD_TGT,
      RD_C1,
      RD_C2
   } rd_sel_type;

   typedef enum logic [1:0] {
      LD_NONE,
      LD_UNIT,
      LD_GATE,
      LD_ERR
   } load_type;

   typedef struct packed {
      logic       accept;
      logic       clear_wr;
      rd_sel_type rd_sel;
      logic       latch_a;
      logic       latch_b;
      logic       idx_inc;
      load_type   load;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic gate_bad;
      logic out_free;
      logic clear_last;
      logic unit_last;
      logic gate_last;
   } sts_type;

endpackage

// ----- hdl/rgce_ram.sv -----
module rgce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/rgce_ctrl.sv -----
module rgce_ctrl
   import rgce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   output logic       req_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FUNC_START, FUNC_FINISH: state_in = ST_UNIT_RD;
                  FUNC_GATE:   state_in = sts.gate_bad ? ST_ERR_EMIT : ST_GATE_RD_T;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_UNIT_RD:    state_in = ST_UNIT_EMIT;
         ST_UNIT_EMIT: begin
            if (sts.out_free) state_in = sts.unit_last ? ST_IDLE : ST_UNIT_RD;
         end
         ST_GATE_RD_T:  state_in = ST_GATE_RD_C1;
         ST_GATE_RD_C1: state_in = ST_GATE_RD_C2;
         ST_GATE_RD_C2: state_in = ST_GATE_EMIT;
         ST_GATE_EMIT: begin
            if (sts.out_free && sts.gate_last) state_in = ST_IDLE;
         end
         ST_ERR_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.rd_sel = RD_NONE;
      cmd.load   = LD_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_UNIT_RD: cmd.rd_sel = RD_UNIT;
         ST_UNIT_EMIT: begin
            if (sts.out_free) begin
               cmd.load    = LD_UNIT;
               cmd.idx_inc = 1'b1;
            end
         end
         ST_GATE_RD_T: cmd.rd_sel = RD_TGT;
         ST_GATE_RD_C1: begin
            cmd.latch_a = 1'b1;
            cmd.rd_sel  = RD_C1;
         end
         ST_GATE_RD_C2: begin
            cmd.latch_b = 1'b1;
            cmd.rd_sel  = RD_C2;
         end
         ST_GATE_EMIT: begin
            if (sts.out_free) begin
               cmd.load    = LD_GATE;
               cmd.idx_inc = 1'b1;
               cmd.commit  = sts.gate_last;
            end
         end
         ST_ERR_EMIT: begin
            if (sts.out_free) cmd.load = LD_ERR;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/rgce_datapath.sv -----
`include "reversible_gate_cnf_emitter_assert.svh"

module rgce_datapath
   import rgce_pkg::*;
#(
   parameter int NUM_WIRES     = 128,
   parameter int ASSERTED_BITS = 64,
   parameter int VAR_WIDTH     = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic [1:0]              req_func,
   input  logic [7:0]              req_target_wire,
   input  logic [7:0]              req_control_one,
   input  logic [7:0]              req_control_two,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [LIT_W-1:0] rsp_lit_first,
   output logic signed [LIT_W-1:0] rsp_lit_second,
   output logic signed [LIT_W-1:0] rsp_lit_third,
   output logic signed [LIT_W-1:0] rsp_lit_fourth,
   output logic [2:0]              rsp_lit_count,
   output logic                    rsp_error_flag,
   output logic                    rsp_last,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [63:0]             csr_pwdata,
   output logic [63:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int WIRE_W   = $clog2(NUM_WIRES);
   localparam int CMP_W    = (WIRE_W + 1 > 8) ? WIRE_W + 1 : 8;
   localparam int NV_W     = (VAR_WIDTH > 32) ? 32 : VAR_WIDTH;
   localparam int LIM_BITS = (VAR_WIDTH > 32) ? 31 : VAR_WIDTH - 1;
   localparam logic [NV_W-1:0] VAR_LIMIT = NV_W'((64'd1 << LIM_BITS) - 64'd1);
   localparam int TAIL_COUNT = (NUM_WIRES - TAIL_FIRST_WIRE > MAX_RESULTS) ?
                               MAX_RESULTS : NUM_WIRES - TAIL_FIRST_WIRE;
   localparam logic [2:0] CSR_TARGET_ADDR = 3'd0;
   localparam logic [2:0] GATE_LAST_IDX   = 3'd5;

   function automatic logic signed [LIT_W-1:0] make_lit(input logic [NV_W-1:0] v,
                                                       input logic neg);
      logic [LIT_W-1:0] x;
      x = LIT_W'(v);
      return neg ? -x : x;
   endfunction

   // bit j set: literal j of the gate clause is negated
   function automatic logic [3:0] gate_neg(input logic [2:0] k);
      logic [3:0] r;
      case (k)
         3'd0:    r = 4'b0111;
         3'd1:    r = 4'b0101;
         3'd2:    r = 4'b0010;
         3'd3:    r = 4'b0000;
         3'd4:    r = 4'b0101;
         3'd5:    r = 4'b1100;
         default: r = 4'b0000;
      endcase
      return r;
   endfunction

   logic [63:0]       target_ff, target_in;
   logic [WIRE_W-1:0] idx_ff, idx_in;
   logic [WIRE_W-1:0] ta_ff, c1_ff, c2_ff;
   logic              tail_ff;
   logic [NV_W-1:0]   a_ff, b_ff;
   logic [NV_W-1:0]   nv_ff, nv_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [LIT_W-1:0] lit1_ff, lit1_in, lit2_ff, lit2_in;
   logic signed [LIT_W-1:0] lit3_ff, lit3_in, lit4_ff, lit4_in;
   logic [2:0]              count_ff, count_in;
   logic                    error_ff, error_in;
   logic                    last_ff, last_in;

   logic              ram_we, ram_re;
   logic [WIRE_W-1:0] ram_waddr, ram_raddr;
   logic [NV_W-1:0]   ram_wdata, ram_rdata;

   logic       csr_wr;
   logic       out_free;
   logic       nv_exhausted;
   logic [2:0] gk;
   logic [3:0] gneg;
   logic [NV_W-1:0] g_v1, g_v2;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_TARGET_ADDR;
   assign csr_prdata = (csr_paddr == CSR_TARGET_ADDR) ? target_ff : 64'd0;
   assign target_in  = csr_wr ? csr_pwdata : target_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign nv_exhausted = nv_ff > VAR_LIMIT;

   always_comb begin
      sts.out_free   = out_free;
      sts.clear_last = idx_ff == WIRE_W'(NUM_WIRES - 1);
      sts.unit_last  = tail_ff ? (idx_ff == WIRE_W'(TAIL_COUNT - 1))
                               : (idx_ff == WIRE_W'(ASSERTED_BITS - 1));
      sts.gate_last  = idx_ff[2:0] == GATE_LAST_IDX;
      sts.gate_bad   = (CMP_W'(req_target_wire) >= CMP_W'(NUM_WIRES)) ||
                       (CMP_W'(req_control_one) >= CMP_W'(NUM_WIRES)) ||
                       (CMP_W'(req_control_two) >= CMP_W'(NUM_WIRES)) ||
                       nv_exhausted;
   end

   // map memory: clearing pass or target remap on write, one read per cycle
   always_comb begin
      ram_we    = cmd.clear_wr || cmd.commit;
      ram_waddr = cmd.clear_wr ? idx_ff : ta_ff;
      ram_wdata = cmd.clear_wr ? NV_W'(idx_ff) + NV_W'(1) : nv_ff;
      ram_re    = cmd.rd_sel != RD_NONE;
      case (cmd.rd_sel)
         RD_UNIT: ram_raddr = tail_ff ? WIRE_W'(TAIL_FIRST_WIRE) + idx_ff : idx_ff;
         RD_TGT:  ram_raddr = ta_ff;
         RD_C1:   ram_raddr = c1_ff;
         RD_C2:   ram_raddr = c2_ff;
         default: ram_raddr = idx_ff;
      endcase
   end

   rgce_ram #(
      .WIDTH (NV_W),
      .DEPTH (NUM_WIRES)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept)       idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + WIRE_W'(1);
      nv_in = cmd.commit ? nv_ff + NV_W'(1) : nv_ff;
   end

   // gate clause literals, the second control's variable read straight from the map output
   assign gk   = idx_ff[2:0];
   assign gneg = gate_neg(gk);
   assign g_v1 = (gk inside {3'd1, 3'd3}) ? ram_rdata : b_ff;
   assign g_v2 = (gk inside {3'd4, 3'd5}) ? ram_rdata : nv_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lit1_in  = lit1_ff;
      lit2_in  = lit2_ff;
      lit3_in  = lit3_ff;
      lit4_in  = lit4_ff;
      count_in = count_ff;
      error_in = error_ff;
      last_in  = last_ff;
      case (cmd.load)
         LD_UNIT: begin
            rsp_valid_in = 1'b1;
            lit1_in  = make_lit(ram_rdata, tail_ff || !target_ff[idx_ff[5:0]]);
            lit2_in  = '0;
            lit3_in  = '0;
            lit4_in  = '0;
            count_in = 3'd1;
            error_in = 1'b0;
            last_in  = sts.unit_last;
         end
         LD_GATE: begin
            rsp_valid_in = 1'b1;
            lit1_in  = make_lit(a_ff, gneg[0]);
            lit2_in  = make_lit(g_v1, gneg[1]);
            lit3_in  = make_lit(g_v2, gneg[2]);
            lit4_in  = (gk >= 3'd4) ? make_lit(nv_ff, gneg[3]) : '0;
            count_in = (gk >= 3'd4) ? 3'd4 : 3'd3;
            error_in = 1'b0;
            last_in  = sts.gate_last;
         end
         LD_ERR: begin
            rsp_valid_in = 1'b1;
            lit1_in  = '0;
            lit2_in  = '0;
            lit3_in  = '0;
            lit4_in  = '0;
            count_in = 3'd0;
            error_in = 1'b1;
            last_in  = 1'b1;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         idx_ff       <= '0;
         nv_ff        <= NV_W'(NUM_WIRES + 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         idx_ff       <= idx_in;
         nv_ff        <= nv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ta_ff   <= WIRE_W'(req_target_wire);
         c1_ff   <= WIRE_W'(req_control_one);
         c2_ff   <= WIRE_W'(req_control_two);
         tail_ff <= req_func == FUNC_FINISH;
      end
      if (cmd.latch_a) a_ff <= ram_rdata;
      if (cmd.latch_b) b_ff <= ram_rdata;
      lit1_ff  <= lit1_in;
      lit2_ff  <= lit2_in;
      lit3_ff  <= lit3_in;
      lit4_ff  <= lit4_in;
      count_ff <= count_in;
      error_ff <= error_in;
      last_ff  <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lit_first  = lit1_ff;
   assign rsp_lit_second = lit2_ff;
   assign rsp_lit_third  = lit3_ff;
   assign rsp_lit_fourth = lit4_ff;
   assign rsp_lit_count  = count_ff;
   assign rsp_error_flag = error_ff;
   assign rsp_last       = last_ff;

   `RGCE_ASSERT_IMPL(a_load_free, cmd.load != LD_NONE, out_free, "clause loaded over a held word")
   `RGCE_ASSERT_NEXT(a_nv_step, cmd.commit, nv_ff == $past(nv_ff) + NV_W'(1), "variable not advanced")
   `RGCE_ASSERT_IMPL(a_commit_room, cmd.commit, !nv_exhausted, "remap with variables exhausted")
   `RGCE_ASSERT_IMPL(a_err_form, rsp_valid_ff && count_ff == 3'd0, error_ff && last_ff, "empty clause not an error word")

endmodule

// ----- hdl/reversible_gate_cnf_emitter.sv -----
// gate word: three map reads, then six clauses, one per cycle while the output is not stalled
// start word: a map read then an emit per clause, ASSERTED_BITS clauses; finish: likewise, up to 64
// bad wire or exhausted variables: one error word and no map read; func 3: accepted, no word
// pacing set by the single read port of the wire map memory, plus output stall
// reset: synchronous; a clearing pass over all NUM_WIRES wires loads wire i with variable i+1,
// requests stall during it, csr writes are taken throughout
module reversible_gate_cnf_emitter
   import rgce_pkg::*;
#(
   parameter int NUM_WIRES     = 128,
   parameter int ASSERTED_BITS = 64,
   parameter int VAR_WIDTH     = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  logic [7:0]              req_target_wire,
   input  logic [7:0]              req_control_one,
   input  logic [7:0]              req_control_two,
   // clause channel, one clause per word
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [LIT_W-1:0] rsp_lit_first,
   output logic signed [LIT_W-1:0] rsp_lit_second,
   output logic signed [LIT_W-1:0] rsp_lit_third,
   output logic signed [LIT_W-1:0] rsp_lit_fourth,
   output logic [2:0]              rsp_lit_count,
   output logic                    rsp_error_flag,
   output logic                    rsp_last,
   // csr port, target word at byte address 0
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [63:0]             csr_pwdata,
   output logic [63:0]             csr_prdata,
   output logic                    csr_pready
);

   // command and status between the sequencer and the datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: clearing pass, map reads, clause emission pacing
   rgce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: wire map memory, fresh variable counter, clause builder,
   // output word register and the target csr
   rgce_datapath #(
      .NUM_WIRES     (NUM_WIRES),
      .ASSERTED_BITS (ASSERTED_BITS),
      .VAR_WIDTH     (VAR_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_target_wire (req_target_wire),
      .req_control_one (req_control_one),
      .req_control_two (req_control_two),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lit_first   (rsp_lit_first),
      .rsp_lit_second  (rsp_lit_second),
      .rsp_lit_third   (rsp_lit_third),
      .rsp_lit_fourth  (rsp_lit_fourth),
      .rsp_lit_count   (rsp_lit_count),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
   import rgce_pkg::*;
();

   localparam int NUM_WIRES     = 128;
   localparam int ASSERTED_BITS = 64;
   localparam int VAR_WIDTH     = 32;

   // largest variable a literal can carry
   localparam logic [31:0] VAR_LIMIT = 32'h7FFF_FFFF;
   // finish emits the wires from the tail start upward, capped at one burst
   localparam int TAIL_WORDS = (NUM_WIRES - TAIL_FIRST_WIRE > MAX_RESULTS) ?
                               MAX_RESULTS : NUM_WIRES - TAIL_FIRST_WIRE;
   // the one func code the block ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   // csr map: target word at byte 0
   localparam logic [2:0] CSR_TARGET_VALUE = 3'd0;
   // settle time after the clause queue runs dry
   localparam int SETTLE_CYCLES = 16;

   typedef logic signed [LIT_W-1:0] lit_type;

   // one clause as it leaves the block
   typedef struct packed {
      lit_type    first;
      lit_type    second;
      lit_type    third;
      lit_type    fourth;
      logic [2:0] count;
      logic       err_flag;
      logic       last;
   } clause_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // request side, the bench-driven signals set from time zero
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [1:0] req_func        = FUNC_UNUSED;
   logic [7:0] req_target_wire = '0;
   logic [7:0] req_control_one = '0;
   logic [7:0] req_control_two = '0;

   // clause side
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   lit_type    rsp_lit_first;
   lit_type    rsp_lit_second;
   lit_type    rsp_lit_third;
   lit_type    rsp_lit_fourth;
   logic [2:0] rsp_lit_count;
   logic       rsp_error_flag;
   logic       rsp_last;

   // csr side
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   reversible_gate_cnf_emitter #(
      .NUM_WIRES     (NUM_WIRES),
      .ASSERTED_BITS (ASSERTED_BITS),
      .VAR_WIDTH     (VAR_WIDTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_target_wire (req_target_wire),
      .req_control_one (req_control_one),
      .req_control_two (req_control_two),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lit_first   (rsp_lit_first),
      .rsp_lit_second  (rsp_lit_second),
      .rsp_lit_third   (rsp_lit_third),
      .rsp_lit_fourth  (rsp_lit_fourth),
      .rsp_lit_count   (rsp_lit_count),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // mirror of the block: wire to variable map, fresh variable, target word
   logic [31:0] wire_var [NUM_WIRES];
   logic [31:0] fresh_var;
   logic [63:0] target_word;

   // clauses predicted but not yet seen, oldest first
   clause_type expected_clauses [$];

   int  bad_words = 0;
   bit  idle_on   = 1'b0;   // sender inserts gaps
   bit  stall_on  = 1'b0;   // receiver stalls
   int  stall_left = 0;

   // short pauses mostly, a long one now and then
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic lit_type lit_of(logic [31:0] v, bit neg);
      return neg ? -v : v;
   endfunction

   function automatic void add_clause(lit_type l1, lit_type l2, lit_type l3, lit_type l4,
                                      logic [2:0] cnt, logic err, logic fin);
      clause_type c;
      c = '{l1, l2, l3, l4, cnt, err, fin};
      expected_clauses.insert(expected_clauses.size(), c);
   endfunction

   // work out the clauses of one accepted word and update the mirror
   function automatic void predict_clauses(logic [1:0] f, logic [7:0] t,
                                           logic [7:0] c1, logic [7:0] c2);
      logic [31:0] a, b, c, n;
      case (f)
         FUNC_START: begin
            // one unit clause per low wire, sign from the target bit
            for (int k = 0; k < ASSERTED_BITS; k++)
               add_clause(lit_of(wire_var[k], !target_word[k]), '0, '0, '0,
                          3'd1, 1'b0, k == ASSERTED_BITS - 1);
         end
         FUNC_FINISH: begin
            // high wires forced false
            for (int k = 0; k < TAIL_WORDS; k++)
               add_clause(lit_of(wire_var[TAIL_FIRST_WIRE + k], 1'b1), '0, '0, '0,
                          3'd1, 1'b0, k == TAIL_WORDS - 1);
         end
         FUNC_GATE: begin
            if (t >= NUM_WIRES || c1 >= NUM_WIRES || c2 >= NUM_WIRES ||
                fresh_var > VAR_LIMIT) begin
               // bad wire or no variables left: lone error word, no state change
               add_clause('0, '0, '0, '0, 3'd0, 1'b1, 1'b1);
            end else begin
               a = wire_var[t];
               b = wire_var[c1];
               c = wire_var[c2];
               n = fresh_var;
               add_clause(lit_of(a, 1'b1), lit_of(b, 1'b1), lit_of(n, 1'b1), '0,
                          3'd3, 1'b0, 1'b0);
               add_clause(lit_of(a, 1'b1), lit_of(c, 1'b0), lit_of(n, 1'b1), '0,
                          3'd3, 1'b0, 1'b0);
               add_clause(lit_of(a, 1'b0), lit_of(b, 1'b1), lit_of(n, 1'b0), '0,
                          3'd3, 1'b0, 1'b0);
               add_clause(lit_of(a, 1'b0), lit_of(c, 1'b0), lit_of(n, 1'b0), '0,
                          3'd3, 1'b0, 1'b0);
               add_clause(lit_of(a, 1'b1), lit_of(b, 1'b0), lit_of(c, 1'b1),
                          lit_of(n, 1'b0), 3'd4, 1'b0, 1'b0);
               add_clause(lit_of(a, 1'b0), lit_of(b, 1'b0), lit_of(c, 1'b1),
                          lit_of(n, 1'b1), 3'd4, 1'b0, 1'b1);
               // target wire now carries the fresh variable
               wire_var[t] = n;
               fresh_var   = n + 1;
            end
         end
         default: begin
            // unused func: nothing out, nothing changes
         end
      endcase
   endfunction

   // receiver stall: random holds, off while reset is high or stalls are disabled
   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= pick_pause();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // clause checker: sample mid-cycle, the word moves at the next rising edge
   always @(negedge clock) begin
      clause_type got;
      clause_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_lit_first, rsp_lit_second, rsp_lit_third, rsp_lit_fourth,
                 rsp_lit_count, rsp_error_flag, rsp_last};
         if (expected_clauses.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("%0t: unexpected word %0d %0d %0d %0d cnt=%0d err=%0b last=%0b",
                        $realtime, got.first, got.second, got.third, got.fourth,
                        got.count, got.err_flag, got.last);
         end else begin
            want = expected_clauses.pop_front();
            if (got.first !== want.first || got.second !== want.second ||
                got.third !== want.third || got.fourth !== want.fourth ||
                got.count !== want.count || got.err_flag !== want.err_flag ||
                got.last !== want.last) begin
               bad_words++;
               if (bad_words <= 10)
                  $display({"%0t: clause mismatch, expected %0d %0d %0d %0d cnt=%0d ",
                            "err=%0b last=%0b, got %0d %0d %0d %0d cnt=%0d err=%0b last=%0b"},
                           $realtime, want.first, want.second, want.third, want.fourth,
                           want.count, want.err_flag, want.last, got.first, got.second,
                           got.third, got.fourth, got.count, got.err_flag, got.last);
            end
         end
      end
   end

   // csr write: setup cycle, access cycle, taken at the edge with pready high
   task automatic csr_write(input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_TARGET_VALUE;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(negedge clock);
      while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      target_word = value;
   endtask

   // send one request word; called and returns at a rising edge
   task automatic send_word(input logic [1:0] f, input logic [7:0] t,
                            input logic [7:0] c1, input logic [7:0] c2);
      int gap;
      gap = idle_on ? pick_pause() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_target_wire <= t;
      req_control_one <= c1;
      req_control_two <= c2;
      // stall is settled by mid-cycle; the word goes at the following edge
      do
         @(negedge clock);
      while (req_stall);
      @(posedge clock);
      predict_clauses(f, t, c1, c2);
   endtask

   // stop sending, wait out every expected clause, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_clauses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // identity map right after reset, target all zero
   task automatic test_reset_map();
      idle_on  = 1'b0;
      stall_on = 1'b0;
      csr_write(64'h0);
      send_word(FUNC_START, 8'd0, 8'd0, 8'd0);
      send_word(FUNC_FINISH, 8'd0, 8'd0, 8'd0);
      drain();
   endtask

   // start clauses under all-ones and mixed target words
   task automatic test_target_extremes();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      csr_write(64'hFFFF_FFFF_FFFF_FFFF);
      send_word(FUNC_START, 8'd0, 8'd0, 8'd0);
      drain();
      csr_write(64'hAAAA_AAAA_5555_5555);
      send_word(FUNC_START, 8'd0, 8'd0, 8'd0);
      drain();
      csr_write(64'h8000_0000_0000_0001);
      send_word(FUNC_START, 8'd0, 8'd0, 8'd0);
      drain();
   endtask

   // gates on the edge wires, repeated targets, then start and finish see the remap
   task automatic test_gate_directed();
      idle_on  = 1'b0;
      stall_on = 1'b1;
      send_word(FUNC_GATE, 8'd0, 8'd0, 8'd0);
      send_word(FUNC_GATE, 8'd127, 8'd126, 8'd125);
      send_word(FUNC_GATE, 8'd127, 8'd127, 8'd127);
      send_word(FUNC_GATE, 8'd64, 8'd0, 8'd127);
      send_word(FUNC_GATE, 8'd0, 8'd64, 8'd64);
      send_word(FUNC_START, 8'd0, 8'd0, 8'd0);
      send_word(FUNC_FINISH, 8'd0, 8'd0, 8'd0);
      drain();
   endtask

   // out-of-range wire in each field, then a legal gate; the bad words must leave the map untouched
   task automatic test_bad_wires();
      idle_on  = 1'b1;
      stall_on = 1'b0;
      send_word(FUNC_GATE, 8'd128, 8'd0, 8'd0);
      send_word(FUNC_GATE, 8'd0, 8'd255, 8'd0);
      send_word(FUNC_GATE, 8'd0, 8'd0, 8'd200);
      send_word(FUNC_GATE, 8'd255, 8'd255, 8'd255);
      send_word(FUNC_GATE, 8'd127, 8'd128, 8'd1);
      send_word(FUNC_GATE, 8'd1, 8'd2, 8'd3);
      drain();
   endtask

   // unused func is swallowed without output
   task automatic test_unused_func();
      idle_on  = 1'b1;
      stall_on = 1'b1;
      send_word(FUNC_UNUSED, 8'd255, 8'd255, 8'd255);
      send_word(FUNC_UNUSED, 8'd0, 8'd0, 8'd0);
      send_word(FUNC_GATE, 8'd2, 8'd1, 8'd0);
      drain();
   endtask

   // random mix, mostly legal gates on a few busy wires so chains build up
   task automatic test_random_mix(input logic [63:0] word, input int count,
                                  input bit pauses);
      int          pick;
      logic [1:0]  f;
      logic [7:0]  w [3];
      idle_on  = pauses;
      stall_on = pauses;
      csr_write(word);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         for (int j = 0; j < 3; j++)
            w[j] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, NUM_WIRES - 1)) :
                                                 8'($urandom_range(0, 7));
         if (pick < 8) begin
            f = FUNC_START;
         end else if (pick < 16) begin
            f = FUNC_FINISH;
         end else if (pick < 21) begin
            f = FUNC_UNUSED;
            for (int j = 0; j < 3; j++)
               w[j] = 8'($urandom_range(0, 255));
         end else begin
            f = FUNC_GATE;
            // some gates carry a bad wire in one field
            if (pick < 29)
               w[2'($urandom_range(0, 2))] = 8'($urandom_range(NUM_WIRES, 255));
         end
         send_word(f, w[0], w[1], w[2]);
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NUM_WIRES; i++)
         wire_var[i] = i + 1;
      fresh_var   = NUM_WIRES + 1;
      target_word = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_map();
      test_target_extremes();
      test_gate_directed();
      test_bad_wires();
      test_unused_func();
      // phases at several target words, one of them with no pauses at all
      test_random_mix({$urandom, $urandom}, 20, 1'b0);
      test_random_mix(64'h0, 20, 1'b1);
      test_random_mix(64'hFFFF_FFFF_FFFF_FFFF, 20, 1'b1);
      test_random_mix({$urandom, $urandom}, 20, 1'b1);

      // anything still queued never showed up
      bad_words += expected_clauses.size();
      if (bad_words == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
